// ===== sv/mwas_pkg.sv =====
// shared types, codes and helpers for the mixed-width aligned stack
// no dependencies; imported by every module of the block
package mwas_pkg;

  // operation codes on in_func
  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_PEEK = 2'd1;
  localparam logic [1:0] FUNC_POP  = 2'd2;

  // result status codes on out_status
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_UNDER = 2'd1;
  localparam logic [1:0] STAT_OVER  = 2'd2;

  // element size codes on in_width_code
  localparam logic [1:0] WC_BYTE  = 2'd0;
  localparam logic [1:0] WC_HALF  = 2'd1;
  localparam logic [1:0] WC_WORD  = 2'd2;
  localparam logic [1:0] WC_DWORD = 2'd3;

  // field widths fixed by the interface
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned FILL_W  = 9;
  localparam int unsigned LANES   = 8;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_HOLD
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;    // word taken this edge: write/read store, update fill
    logic load_out;  // capture result into output registers
  } cmd_t;

  // bit mask covering the bytes of one element
  function automatic logic [VALUE_W-1:0] size_mask(input logic [1:0] wc);
    logic [VALUE_W-1:0] m;
    case (wc)
      WC_BYTE:  m = 64'h0000_0000_0000_00FF;
      WC_HALF:  m = 64'h0000_0000_0000_FFFF;
      WC_WORD:  m = 64'h0000_0000_FFFF_FFFF;
      WC_DWORD: m = 64'hFFFF_FFFF_FFFF_FFFF;
      default:  m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/mwas_ctrl.sv =====
// controller state machine of the mixed-width aligned stack
// depends on mwas_pkg; drives the handshakes and datapath commands
module mwas_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output mwas_pkg::cmd_t cmd
);
  import mwas_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;
  logic   out_take;

  // handshake decode
  assign out_take = (state_r == S_HOLD) && !out_stall;
  assign in_stall = !((state_r == S_IDLE) || out_take);
  assign accept   = in_valid && !in_stall;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_take) state_nxt = accept ? S_EXEC : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.accept   = accept;
    cmd.load_out = 1'b0;
    out_valid    = 1'b0;
    case (state_r)
      S_IDLE: ;
      S_EXEC: cmd.load_out = 1'b1;
      S_HOLD: out_valid = 1'b1;
      default: ;
    endcase
  end

  // a word is never taken while the store read is in flight
  a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> !accept)
    else $error("word accepted during execute");

  // every accepted word is executed in the next cycle
  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC) && cmd.load_out)
    else $error("accepted word not executed");

  // a taken result with no new word returns to idle and shows no result
  a_take_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !accept) |=> (state_r == S_IDLE) && !out_valid)
    else $error("result repeated after it was taken");

endmodule

// ===== sv/mwas_datapath.sv =====
// datapath of the mixed-width aligned stack: fill level, byte store, result regs
// depends on mwas_pkg; driven by mwas_ctrl commands
module mwas_datapath #(
  parameter int unsigned STORE_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mwas_pkg::cmd_t                cmd,
  input  logic [1:0]                    in_func,
  input  logic [1:0]                    in_width_code,
  input  logic [mwas_pkg::VALUE_W-1:0]  in_push_value,
  output logic [mwas_pkg::VALUE_W-1:0]  out_read_value,
  output logic [1:0]                    out_status,
  output logic [mwas_pkg::FILL_W-1:0]   out_fill_bytes
);
  import mwas_pkg::*;

  // fill level width, and a wider width for round-up and end-of-element sums
  localparam int unsigned FLW  = $clog2(STORE_BYTES + 1);
  localparam int unsigned FWA  = $clog2(STORE_BYTES + 8) + 1;
  localparam int unsigned FW   = (FWA > FILL_W) ? FWA : FILL_W;
  // store is organized as rows of eight byte lanes
  localparam int unsigned ROWS = (STORE_BYTES + LANES - 1) / LANES;
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [FLW-1:0]     fill_r, fill_nxt;
  logic [FW-1:0]      fill_x, size_x, base_x, end_x, off_x, store_x, row_base_x;
  logic               is_push, is_read, over, under, do_write;
  logic [FW-1:0]      addr_x;
  logic [RW-1:0]      row_sel;
  logic [2:0]         lane_sel;
  logic [LANES-1:0]   byte_en, beyond_ok;
  logic [VALUE_W-1:0] wdata;
  logic [1:0]         status_c;

  logic [7:0]         store_mem [ROWS][LANES];
  logic [7:0]         rd_row_r [LANES];

  logic [1:0]         pend_status_r;
  logic               pend_read_r;
  logic [2:0]         pend_lane_r;
  logic [1:0]         pend_wc_r;
  logic [LANES-1:0]   pend_ok_r;

  logic [VALUE_W-1:0] row_masked, row_shifted, result_c;
  logic [VALUE_W-1:0] out_read_value_r;
  logic [1:0]         out_status_r;
  logic [FILL_W-1:0]  out_fill_bytes_r;

  // address arithmetic on the current fill level
  always_comb begin
    fill_x  = {{(FW-FLW){1'b0}}, fill_r};
    store_x = FW'(STORE_BYTES);
    size_x  = FW'(1) << in_width_code;
    base_x  = (fill_x + size_x - FW'(1)) & ~(size_x - FW'(1));
    end_x   = base_x + size_x;
    off_x   = base_x - size_x;
    is_push = (in_func == FUNC_PUSH);
    is_read = (in_func == FUNC_PEEK) || (in_func == FUNC_POP);
    over    = end_x > store_x;
    under   = fill_x < size_x;
    do_write = is_push && !over;
  end

  // row and lane of the element, and lane write enables
  always_comb begin
    addr_x     = is_push ? base_x : off_x;
    row_sel    = addr_x[RW+2:3];
    lane_sel   = addr_x[2:0];
    row_base_x = {addr_x[FW-1:3], 3'b000};
    wdata      = in_push_value << {lane_sel, 3'b000};
    for (int k = 0; k < LANES; k++) begin
      byte_en[k]   = (4'(k) >= {1'b0, lane_sel}) &&
                     (5'(k) < ({2'b00, lane_sel} + size_x[4:0]));
      beyond_ok[k] = (row_base_x + FW'(k)) < store_x;
    end
  end

  // status of this word
  always_comb begin
    status_c = STAT_OK;
    if (is_push && over) status_c = STAT_OVER;
    else if (is_read && under) status_c = STAT_UNDER;
  end

  // fill level update
  always_comb begin
    fill_nxt = fill_r;
    if (cmd.accept) begin
      if (do_write) fill_nxt = end_x[FLW-1:0];
      else if ((in_func == FUNC_POP) && !under) fill_nxt = off_x[FLW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // byte store: one row written or read per word, read data registered
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int k = 0; k < LANES; k++) begin
        if (do_write && byte_en[k]) store_mem[row_sel][k] <= wdata[8*k +: 8];
        rd_row_r[k] <= store_mem[row_sel][k];
      end
    end
  end

  // word context held across the store read
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_status_r <= status_c;
      pend_read_r   <= is_read && !under;
      pend_lane_r   <= lane_sel;
      pend_wc_r     <= in_width_code;
      pend_ok_r     <= beyond_ok;
    end
  end

  // pick the element out of the row, bytes past the store read zero
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      row_masked[8*k +: 8] = pend_ok_r[k] ? rd_row_r[k] : 8'h00;
    end
    row_shifted = row_masked >> {pend_lane_r, 3'b000};
    result_c    = pend_read_r ? (row_shifted & size_mask(pend_wc_r)) : '0;
  end

  // output registers
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_read_value_r <= result_c;
      out_status_r     <= pend_status_r;
      out_fill_bytes_r <= fill_x[FILL_W-1:0];
    end
  end

  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_fill_bytes = out_fill_bytes_r;

  // fill level never passes the store size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_x <= store_x)
    else $error("fill level beyond store");

  // an overflowing push leaves the fill level alone
  a_over_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && is_push && over) |=> $stable(fill_r))
    else $error("overflowing push changed fill level");

  // an underflow result carries zero
  a_under_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && (pend_status_r == STAT_UNDER)) |=> (out_read_value == '0))
    else $error("underflow result not zero");

endmodule

// ===== sv/mixed_width_aligned_stack.sv =====
// top level of the mixed-width aligned stack
// depends on mwas_pkg, mwas_ctrl and mwas_datapath
//
// Byte-addressed LIFO of STORE_BYTES bytes holding 1, 2, 4 or 8 byte elements,
// each aligned to its own size and stored little-endian. Every word on the
// input channel (push, peek, pop or the unused code) gives exactly one result
// word carrying the element read, a status (ok, underflow, overflow) and the
// fill level after the operation. A word first has its store row accessed,
// with the read data registered, and then its result formed in the output
// register. The next word is taken no sooner than its predecessor's result
// is taken, so no new word enters while one is still in flight. The store
// needs no clearing pass after reset; bytes never pushed read back as undefined.
module mixed_width_aligned_stack #(
  parameter int unsigned STORE_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_func,
  input  logic [1:0]                    in_width_code,
  input  logic [mwas_pkg::VALUE_W-1:0]  in_push_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mwas_pkg::VALUE_W-1:0]  out_read_value,
  output logic [1:0]                    out_status,
  output logic [mwas_pkg::FILL_W-1:0]   out_fill_bytes
);
  import mwas_pkg::*;

  cmd_t cmd;

  // handshake and sequencing
  mwas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // store, fill level and result registers
  mwas_datapath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_func        (in_func),
    .in_width_code  (in_width_code),
    .in_push_value  (in_push_value),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_fill_bytes (out_fill_bytes)
  );

endmodule

// ===== dv/stack_checker.sv =====
// scoreboard for the mixed-width aligned stack: predicts each result word and compares
// depends on mwas_pkg; watches both channels of the block from beside it
module stack_checker #(
  parameter int unsigned STORE_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [1:0]                    in_func,
  input  logic [1:0]                    in_width_code,
  input  logic [mwas_pkg::VALUE_W-1:0]  in_push_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [mwas_pkg::VALUE_W-1:0]  out_read_value,
  input  logic [1:0]                    out_status,
  input  logic [mwas_pkg::FILL_W-1:0]   out_fill_bytes,
  output int                            fail_count,
  output int                            pending,
  output int                            checked,
  output int                            overflows,
  output int                            underflows
);
  timeunit 1ns;
  timeprecision 1ps;
  import mwas_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [1:0]         status;
    logic [FILL_W-1:0]  fill;
  } stack_result_t;

  // predicted stack contents and fill level
  logic [7:0]    stack_bytes [STORE_BYTES];
  int unsigned   stack_fill = 0;
  stack_result_t result_q[$];

  int n_fail = 0;
  int n_pending = 0;
  int n_checked = 0;
  int n_over = 0;
  int n_under = 0;

  assign fail_count = n_fail;
  assign pending    = n_pending;
  assign checked    = n_checked;
  assign overflows  = n_over;
  assign underflows = n_under;

  function automatic int unsigned align_up(input int unsigned x, input int unsigned size);
    return ((x + size - 1) / size) * size;
  endfunction

  // apply one word to the predicted stack and form its result
  task automatic stack_apply(input logic [1:0] func, input logic [1:0] wc,
                             input logic [VALUE_W-1:0] val, output stack_result_t res);
    int unsigned size;
    int unsigned base;
    int unsigned off;
    size = 1 << wc;
    res = '0;
    res.status = STAT_OK;
    case (func)
      FUNC_PUSH: begin
        base = align_up(stack_fill, size);
        if (base + size > STORE_BYTES) begin
          res.status = STAT_OVER;
          n_over++;
        end else begin
          for (int i = 0; i < size; i++) stack_bytes[base + i] = val[8*i +: 8];
          stack_fill = base + size;
        end
      end
      FUNC_PEEK, FUNC_POP: begin
        if (stack_fill < size) begin
          res.status = STAT_UNDER;
          n_under++;
        end else begin
          off = align_up(stack_fill, size) - size;
          for (int i = 0; i < size; i++) begin
            if (off + i < STORE_BYTES) res.value[8*i +: 8] = stack_bytes[off + i];
          end
          if (func == FUNC_POP) stack_fill = off;
        end
      end
      default: ;
    endcase
    res.fill = stack_fill[FILL_W-1:0];
  endtask

  always @(posedge clk) begin : monitor
    stack_result_t want;
    stack_result_t got;
    if (!rst_n) begin
      stack_fill = 0;
      result_q.delete();
    end else begin
      // result words are matched against the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{value: out_read_value, status: out_status, fill: out_fill_bytes};
        if (result_q.size() == 0) begin
          $error("result word with nothing expected: read_value %h status %0d fill_bytes %0d",
                 got.value, got.status, got.fill);
          n_fail++;
        end else begin
          want = result_q.pop_front();
          n_checked++;
          if (got.value !== want.value) begin
            $error("read_value mismatch: expected %h, got %h", want.value, got.value);
            n_fail++;
          end
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, got.status);
            n_fail++;
          end
          if (got.fill !== want.fill) begin
            $error("fill_bytes mismatch: expected %0d, got %0d", want.fill, got.fill);
            n_fail++;
          end
        end
      end
      // each accepted input word yields one prediction
      if (in_valid && !in_stall) begin
        stack_apply(in_func, in_width_code, in_push_value, want);
        result_q.push_back(want);
      end
    end
    n_pending = result_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// top of the stack testbench: clock, reset, stimulus, output stalls and verdict
// depends on mwas_pkg, mixed_width_aligned_stack and stack_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mwas_pkg::*;

  localparam int unsigned STORE_BYTES = 256;
  localparam int          QUIET_LIMIT = 3000;
  localparam int          HOLD_CYCLES = 80;
  localparam int          PHASE_WORDS = 400;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_func = FUNC_PUSH;
  logic [1:0]           in_width_code = WC_BYTE;
  logic [VALUE_W-1:0]   in_push_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [VALUE_W-1:0]   out_read_value;
  logic [1:0]           out_status;
  logic [FILL_W-1:0]    out_fill_bytes;

  int fail_count, pending, checked, overflows, underflows;

  // knobs shared by the sender and the receiver
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;

  // sender's view of the stack, used to keep reads off bytes never pushed
  int unsigned            shadow_fill = 0;
  bit [STORE_BYTES-1:0]   shadow_written = '0;
  int n_push = 0, n_peek = 0, n_pop = 0, n_unused = 0;

  mixed_width_aligned_stack #(.STORE_BYTES(STORE_BYTES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_width_code(in_width_code), .in_push_value(in_push_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_read_value(out_read_value), .out_status(out_status), .out_fill_bytes(out_fill_bytes)
  );

  stack_checker #(.STORE_BYTES(STORE_BYTES)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_width_code(in_width_code), .in_push_value(in_push_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_read_value(out_read_value), .out_status(out_status), .out_fill_bytes(out_fill_bytes),
    .fail_count(fail_count), .pending(pending), .checked(checked),
    .overflows(overflows), .underflows(underflows)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, or one long hold when asked
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb_top failed");
    $finish;
  end

  function automatic int unsigned align_up(input int unsigned x, input int unsigned size);
    return ((x + size - 1) / size) * size;
  endfunction

  // a read is allowed if it underflows or covers only pushed bytes
  function automatic bit read_is_safe(input logic [1:0] wc);
    int unsigned size;
    int unsigned off;
    size = 1 << wc;
    if (shadow_fill < size) return 1'b1;
    off = align_up(shadow_fill, size) - size;
    for (int i = 0; i < size; i++) begin
      if (!shadow_written[off + i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // offer one word after random idle cycles, wait for it to be taken
  task automatic send_word(input logic [1:0] func, input logic [1:0] wc,
                           input logic [VALUE_W-1:0] val);
    int unsigned size;
    int unsigned base;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= func;
    in_width_code <= wc;
    in_push_value <= val;
    do @(posedge clk); while (in_stall);
    // track fill and written bytes the same way the stack does
    size = 1 << wc;
    case (func)
      FUNC_PUSH: begin
        n_push++;
        base = align_up(shadow_fill, size);
        if (base + size <= STORE_BYTES) begin
          for (int i = 0; i < size; i++) shadow_written[base + i] = 1'b1;
          shadow_fill = base + size;
        end
      end
      FUNC_PEEK: n_peek++;
      FUNC_POP: begin
        n_pop++;
        if (shadow_fill >= size) shadow_fill = align_up(shadow_fill, size) - size;
      end
      default: n_unused++;
    endcase
  endtask

  // one random word, pushes taking about push_pct percent of the traffic
  task automatic send_random(input int push_pct);
    logic [1:0]         func;
    logic [1:0]         wc;
    logic [VALUE_W-1:0] val;
    bit                 found;
    wc = 2'($urandom_range(3));
    case ($urandom_range(15))
      0:       val = '0;
      1:       val = '1;
      default: val = {$urandom, $urandom};
    endcase
    if ($urandom_range(99) < 2) begin
      func = FUNC_UNUSED;
    end else if ($urandom_range(99) < push_pct) begin
      func = FUNC_PUSH;
    end else begin
      func = $urandom_range(1) ? FUNC_POP : FUNC_PEEK;
      // try other widths if this one would read a padding hole
      found = 1'b0;
      for (int k = 0; k < 4 && !found; k++) begin
        if (read_is_safe(wc)) found = 1'b1;
        else wc = wc + 2'd1;
      end
      if (!found) func = FUNC_PUSH;
    end
    send_word(func, wc, val);
  endtask

  // segments of random length, each picked at random among filling, draining and balanced traffic
  task automatic run_phase(input int words, input int idle_pct, input int stall_pct);
    int remaining;
    int seg;
    int bias;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    remaining = words;
    while (remaining > 0) begin
      seg = $urandom_range(120, 20);
      case ($urandom_range(2))
        0:       bias = 85;
        1:       bias = 50;
        default: bias = 15;
      endcase
      for (int j = 0; j < seg && remaining > 0; j++) begin
        send_random(bias);
        remaining--;
      end
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // underflow on empty stack and the unused code
    send_word(FUNC_POP,    WC_BYTE,  '0);
    send_word(FUNC_PEEK,   WC_DWORD, '0);
    send_word(FUNC_UNUSED, WC_HALF,  '1);
    // each width, with alignment padding after the byte
    send_word(FUNC_PUSH, WC_BYTE,  64'hFFFF_FFFF_FFFF_FFA5);
    send_word(FUNC_PUSH, WC_HALF,  64'h0123_4567_89AB_CDEF);
    send_word(FUNC_PUSH, WC_WORD,  64'hFFFF_FFFF_0000_0000);
    send_word(FUNC_PUSH, WC_DWORD, '1);
    send_word(FUNC_PUSH, WC_DWORD, 64'h8000_0000_0000_0001);
    // narrower reads inside a wide element
    send_word(FUNC_PEEK, WC_DWORD, '0);
    send_word(FUNC_PEEK, WC_BYTE,  '0);
    send_word(FUNC_POP,  WC_WORD,  '0);
    send_word(FUNC_POP,  WC_HALF,  '0);
    send_word(FUNC_POP,  WC_BYTE,  '0);
    send_word(FUNC_PUSH, WC_BYTE,  64'h5A);
    // wider pop rounds the fill level up first
    send_word(FUNC_POP,  WC_DWORD, '0);
    send_word(FUNC_POP,  WC_DWORD, '0);
    send_word(FUNC_PEEK, WC_HALF,  '0);
    send_word(FUNC_POP,  WC_WORD,  '0);
    send_word(FUNC_POP,  WC_HALF,  '0);
    // underflow with a nonzero fill level
    send_word(FUNC_PEEK, WC_WORD,  '0);
    send_word(FUNC_PUSH, WC_BYTE,  '0);
    send_word(FUNC_POP,  WC_BYTE,  '0);

    run_phase(PHASE_WORDS, 0, 0);
    // long output hold while the sender keeps sending mostly pushes
    hold_req = 1'b1;
    for (int j = 0; j < 30; j++) send_random(85);
    run_phase(PHASE_WORDS, 71, 0);
    run_phase(PHASE_WORDS, 0, 71);
    run_phase(PHASE_WORDS, 18, 18);
    in_valid <= 1'b0;

    // drain, then keep watching for anything stray
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("ran %0d pushes, %0d peeks, %0d pops and %0d unused-code words; %0d results checked",
             n_push, n_peek, n_pop, n_unused, checked);
    $display("saw %0d overflowing pushes and %0d underflowing reads across idle and stall mixes",
             overflows, underflows);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
